FILE: design/pairwise_softened_force_unit_assert.svh
// Assertion macros shared by the checker of the pairwise force unit.
`ifndef PAIRWISE_SOFTENED_FORCE_UNIT_ASSERT_SVH
`define PAIRWISE_SOFTENED_FORCE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PWSF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwsf assertion failed");

// Next-cycle implication, disabled during reset.
`define PWSF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwsf assertion failed");

`endif

FILE: design/pwsf_pkg.sv
// Shared types and constants of the pairwise softened force unit.
package pwsf_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_W = 192;
  localparam int unsigned OUT_W = 104;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOFT_FLOOR = 2'd0,
    REG_DIST_DIV   = 2'd1,
    REG_FORCE_GAIN = 2'd2,
    REG_HALF_WIDTH = 2'd3
  } cfg_reg_t;

  localparam logic [31:0] SOFT_FLOOR_RST = 32'd6554;
  localparam logic [15:0] DIST_DIV_RST   = 16'd50;
  localparam logic [7:0]  FORCE_GAIN_RST = 8'd4;
  localparam logic [31:0] HALF_WIDTH_RST = 32'd72090;

  // Per-item flags carried alongside the arithmetic
  typedef struct packed {
    logic xpos;
    logic xneg;
    logic ypos;
    logic yneg;
    logic coll;
    logic zero;
  } side_t;

endpackage

FILE: design/pairwise_softened_force_unit.sv
// Pairwise softened force unit, fully pipelined: one particle pair per clock unless held.
//
// Takes one transaction per clock unless stalled; returns one result per transaction.
// The depth comes from the restoring dividers and the square root, which resolve one
// quotient or root bit per stage: 32 stages for the scaled distance, 46 for the force
// magnitude, and the direction's square root (32) and division (15) run alongside. The
// whole pipeline advances together and holds while the output register waits for
// m_axis_tready. Configuration writes are taken at any time and must only happen while
// the pipeline holds no item.
module pairwise_softened_force_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // self_x, self_y, self_mass, other_x, other_y, other_mass (32 bits each, lowest first)
  input  logic [pwsf_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // force_x[31:0], force_y[63:32], dir_x[79:64], dir_y[95:80], collides[96],
  // saturated[97], zero fill above
  output logic [pwsf_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pwsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwsf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pwsf_pkg::*;

  localparam int DDIV_N = 32;
  localparam int MDIV_N = 46;
  localparam int SQRT_N = 32;
  localparam int DIR_N  = 15;
  localparam int DLY_N  = 30;
  localparam int LAT    = 87;
  localparam int ST_RND = 86;

  function automatic logic [32:0] sat_force(input logic [47:0] m, input logic pos);
    logic [32:0] r;
    if (pos) begin
      if (m > 48'h0000_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'd0 - m[31:0]};
    end else begin
      if (m > 48'h0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, m[31:0]};
    end
    return r;
  endfunction

  // configuration
  logic [31:0] soft_floor;
  logic [15:0] dist_div;
  logic [7:0]  gain;
  logic [31:0] half_width;
  logic [15:0] dv;

  assign cfg_ready = 1'b1;
  assign dv = (dist_div == 16'd0) ? 16'd1 : dist_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_floor <= SOFT_FLOOR_RST;
      dist_div   <= DIST_DIV_RST;
      gain       <= FORCE_GAIN_RST;
      half_width <= HALF_WIDTH_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOFT_FLOOR: soft_floor <= cfg_data;
        REG_DIST_DIV:   dist_div   <= cfg_data[15:0];
        REG_FORCE_GAIN: gain       <= cfg_data[7:0];
        REG_HALF_WIDTH: half_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic           en;
  logic [LAT:1]   vld;

  assign en = !vld[LAT] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], s_axis_tvalid};
    end
  end

  // stage 1: offsets
  logic [32:0] dx1, dy1;
  logic [31:0] m1_1, m2_1;
  logic [31:0] sx, sy, ox, oy;

  assign sx = s_axis_tdata[31:0];
  assign sy = s_axis_tdata[63:32];
  assign ox = s_axis_tdata[127:96];
  assign oy = s_axis_tdata[159:128];

  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= {sx[31], sx} - {ox[31], ox};
      dy1  <= {sy[31], sy} - {oy[31], oy};
      m1_1 <= s_axis_tdata[95:64];
      m2_1 <= s_axis_tdata[191:160];
    end
  end

  // stage 2: magnitudes, flags, mass product
  logic [32:0] ax_c, ay_c;
  side_t       side_c;
  side_t       sd [2:ST_RND];
  logic [31:0] a2, b2;
  logic [63:0] m12_2;

  assign ax_c = dx1[32] ? (33'd0 - dx1) : dx1;
  assign ay_c = dy1[32] ? (33'd0 - dy1) : dy1;

  always_comb begin
    side_c.xpos = !dx1[32] && (dx1 != 33'd0);
    side_c.xneg = dx1[32];
    side_c.ypos = !dy1[32] && (dy1 != 33'd0);
    side_c.yneg = dy1[32];
    side_c.coll = (ax_c[31:0] < half_width) && (ay_c[31:0] < half_width);
    side_c.zero = (ax_c == 33'd0) && (ay_c == 33'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2    <= ax_c[31:0];
      b2    <= ay_c[31:0];
      m12_2 <= m1_1 * m2_1;
      sd[2] <= side_c;
      for (int i = 3; i <= ST_RND; i++) sd[i] <= sd[i-1];
    end
  end

  // stage 3: squares, gain products, first normalising shift
  logic [63:0] sqa3, sqb3;
  logic [39:0] plo3, phi3;
  logic [31:0] na3, nb3, mx2;

  assign mx2 = (a2 > b2) ? a2 : b2;

  always_ff @(posedge clk) begin
    if (en) begin
      sqa3 <= a2 * a2;
      sqb3 <= b2 * b2;
      plo3 <= m12_2[31:0] * gain;
      phi3 <= m12_2[63:32] * gain;
      if (mx2[31]) begin
        na3 <= a2 >> 1;
        nb3 <= b2 >> 1;
      end else if (mx2 < 32'h0000_8000) begin
        na3 <= a2 << 16;
        nb3 <= b2 << 16;
      end else begin
        na3 <= a2;
        nb3 <= b2;
      end
    end
  end

  // stage 4: scaled squared distance, numerator, shifts by 8 and 4
  logic [64:0] sum65;
  logic [48:0] t4;
  logic        dsat4;
  logic [71:0] n4;
  logic [31:0] mx3, x8a, x8b, mx8, na4, nb4;
  logic        s8, s4;

  assign sum65 = {1'b0, sqa3} + {1'b0, sqb3};
  assign mx3   = (na3 > nb3) ? na3 : nb3;
  assign s8    = mx3 < 32'h0080_0000;
  assign x8a   = s8 ? (na3 << 8) : na3;
  assign x8b   = s8 ? (nb3 << 8) : nb3;
  assign mx8   = s8 ? (mx3 << 8) : mx3;
  assign s4    = mx8 < 32'h0800_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      t4    <= sum65[64:16];
      dsat4 <= sum65[64:48] >= {1'b0, dv};
      n4    <= {phi3, 32'd0} + {32'd0, plo3};
      na4   <= s4 ? (x8a << 4) : x8a;
      nb4   <= s4 ? (x8b << 4) : x8b;
    end
  end

  // stage 5: shifts by 2 and 1, leaving max(na, nb) in [2^30, 2^31)
  logic [31:0] mx4, x2a, x2b, mx2b, na5, nb5;
  logic        s2, s1;

  assign mx4  = (na4 > nb4) ? na4 : nb4;
  assign s2   = mx4 < 32'h2000_0000;
  assign x2a  = s2 ? (na4 << 2) : na4;
  assign x2b  = s2 ? (nb4 << 2) : nb4;
  assign mx2b = s2 ? (mx4 << 2) : mx4;
  assign s1   = mx2b < 32'h4000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      na5 <= s1 ? (x2a << 1) : x2a;
      nb5 <= s1 ? (x2b << 1) : x2b;
    end
  end

  // distance divider, stages 5 to 36, quotient known below 2^32 unless saturated
  logic [48:0] drem [0:DDIV_N-1];
  logic [31:0] dq   [0:DDIV_N-1];
  logic        dsat [0:DDIV_N-1];
  logic [71:0] nd   [0:DDIV_N-1];

  for (genvar j = 0; j < DDIV_N; j++) begin : g_ddiv
    logic [48:0] r_in, dsh;
    logic [31:0] q_in;
    logic        s_in, ge;
    logic [71:0] n_in;
    if (j == 0) begin : g_first
      assign r_in = t4;
      assign q_in = '0;
      assign s_in = dsat4;
      assign n_in = n4;
    end else begin : g_rest
      assign r_in = drem[j-1];
      assign q_in = dq[j-1];
      assign s_in = dsat[j-1];
      assign n_in = nd[j-1];
    end
    assign dsh = {33'd0, dv} << (DDIV_N - 1 - j);
    assign ge  = r_in >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        drem[j] <= ge ? (r_in - dsh) : r_in;
        dq[j]   <= {q_in[30:0], ge};
        dsat[j] <= s_in;
        nd[j]   <= n_in;
      end
    end
  end

  // stage 37: clip, softening floor
  logic [31:0] dq_f, dmx, dist37;
  logic [71:0] n37;

  assign dq_f = dsat[DDIV_N-1] ? 32'hFFFF_FFFF : dq[DDIV_N-1];
  assign dmx  = (dq_f < soft_floor) ? soft_floor : dq_f;

  always_ff @(posedge clk) begin
    if (en) begin
      dist37 <= (dmx == 32'd0) ? 32'd1 : dmx;
      n37    <= nd[DDIV_N-1];
    end
  end

  // magnitude divider, stages 38 to 83, capped at 2^46
  logic [71:0] mrem  [0:MDIV_N-1];
  logic [45:0] mq    [0:MDIV_N-1];
  logic        msat  [0:MDIV_N-1];
  logic [31:0] mdist [0:MDIV_N-1];

  for (genvar j = 0; j < MDIV_N; j++) begin : g_mdiv
    logic [71:0] r_in;
    logic [45:0] q_in;
    logic        s_in, ge;
    logic [31:0] d_in;
    logic [77:0] dsh;
    if (j == 0) begin : g_first
      assign r_in = n37;
      assign q_in = '0;
      assign s_in = {6'd0, n37[71:46]} >= dist37;
      assign d_in = dist37;
    end else begin : g_rest
      assign r_in = mrem[j-1];
      assign q_in = mq[j-1];
      assign s_in = msat[j-1];
      assign d_in = mdist[j-1];
    end
    assign dsh = {46'd0, d_in} << (MDIV_N - 1 - j);
    assign ge  = {6'd0, r_in} >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        mrem[j]  <= ge ? (r_in - dsh[71:0]) : r_in;
        mq[j]    <= {q_in[44:0], ge};
        msat[j]  <= s_in;
        mdist[j] <= d_in;
      end
    end
  end

  // stage 84: magnitude
  logic [46:0] mag84;

  always_ff @(posedge clk) begin
    if (en) begin
      mag84 <= msat[MDIV_N-1] ? (47'd1 << 46) : {1'b0, mq[MDIV_N-1]};
    end
  end

  // direction: stages 6 and 7, squared length of the normalised offset
  logic [63:0] sqx6, sqy6, n7;
  logic [31:0] na6, nb6, na7, nb7;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx6 <= na5 * na5;
      sqy6 <= nb5 * nb5;
      na6  <= na5;
      nb6  <= nb5;
      n7   <= sqx6 + sqy6;
      na7  <= na6;
      nb7  <= nb6;
    end
  end

  // square root, stages 8 to 39, one root bit per stage
  logic [33:0] srem  [0:SQRT_N-1];
  logic [31:0] sroot [0:SQRT_N-1];
  logic [63:0] sn    [0:SQRT_N-1];
  logic [31:0] sna   [0:SQRT_N-1];
  logic [31:0] snb   [0:SQRT_N-1];

  for (genvar j = 0; j < SQRT_N; j++) begin : g_sqrt
    logic [33:0] rem_in;
    logic [31:0] root_in, a_in, b_in;
    logic [63:0] n_in;
    logic [35:0] r, trial, r_sub;
    logic        ge;
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = n7;
      assign a_in    = na7;
      assign b_in    = nb7;
    end else begin : g_rest
      assign rem_in  = srem[j-1];
      assign root_in = sroot[j-1];
      assign n_in    = sn[j-1];
      assign a_in    = sna[j-1];
      assign b_in    = snb[j-1];
    end
    assign r     = {rem_in, n_in[63-2*j -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = r >= trial;
    assign r_sub = r - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        srem[j]  <= ge ? r_sub[33:0] : r[33:0];
        sroot[j] <= {root_in[30:0], ge};
        sn[j]    <= n_in;
        sna[j]   <= a_in;
        snb[j]   <= b_in;
      end
    end
  end

  // direction divider, stages 40 to 54, rounded quotient up to 16384
  logic [45:0] rxq [0:DIR_N-1];
  logic [45:0] ryq [0:DIR_N-1];
  logic [14:0] qx  [0:DIR_N-1];
  logic [14:0] qy  [0:DIR_N-1];
  logic [31:0] dln [0:DIR_N-1];

  for (genvar j = 0; j < DIR_N; j++) begin : g_ddir
    logic [45:0] rx_in, ry_in, dsh;
    logic [14:0] qx_in, qy_in;
    logic [31:0] l_in;
    logic        gex, gey;
    if (j == 0) begin : g_first
      assign l_in  = sroot[SQRT_N-1];
      assign rx_in = {sna[SQRT_N-1], 14'd0} + {15'd0, sroot[SQRT_N-1][31:1]};
      assign ry_in = {snb[SQRT_N-1], 14'd0} + {15'd0, sroot[SQRT_N-1][31:1]};
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_rest
      assign l_in  = dln[j-1];
      assign rx_in = rxq[j-1];
      assign ry_in = ryq[j-1];
      assign qx_in = qx[j-1];
      assign qy_in = qy[j-1];
    end
    assign dsh = {14'd0, l_in} << (DIR_N - 1 - j);
    assign gex = rx_in >= dsh;
    assign gey = ry_in >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rxq[j] <= gex ? (rx_in - dsh) : rx_in;
        ryq[j] <= gey ? (ry_in - dsh) : ry_in;
        qx[j]  <= {qx_in[13:0], gex};
        qy[j]  <= {qy_in[13:0], gey};
        dln[j] <= l_in;
      end
    end
  end

  // align direction with the magnitude, stages 55 to 84
  logic [14:0] dlx [0:DLY_N-1];
  logic [14:0] dly [0:DLY_N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dlx[0] <= qx[DIR_N-1];
      dly[0] <= qy[DIR_N-1];
      for (int k = 1; k < DLY_N; k++) begin
        dlx[k] <= dlx[k-1];
        dly[k] <= dly[k-1];
      end
    end
  end

  // stage 85: partial products; stage 86: sum and rounding
  logic [38:0] pxl, pyl;
  logic [37:0] pxh, pyh;
  logic [14:0] dir85x, dir85y, dir86x, dir86y;
  logic [61:0] fxs, fys;
  logic [47:0] fm86x, fm86y;

  assign fxs = {23'd0, pxl} + {pxh, 24'd0} + 62'd8192;
  assign fys = {23'd0, pyl} + {pyh, 24'd0} + 62'd8192;

  always_ff @(posedge clk) begin
    if (en) begin
      pxl    <= dlx[DLY_N-1] * mag84[23:0];
      pxh    <= dlx[DLY_N-1] * mag84[46:24];
      pyl    <= dly[DLY_N-1] * mag84[23:0];
      pyh    <= dly[DLY_N-1] * mag84[46:24];
      dir85x <= dlx[DLY_N-1];
      dir85y <= dly[DLY_N-1];
      fm86x  <= fxs[61:14];
      fm86y  <= fys[61:14];
      dir86x <= dir85x;
      dir86y <= dir85y;
    end
  end

  // stage 87: sign, saturation, output register
  logic [32:0] frx, fry;
  logic [31:0] fx_o, fy_o;
  logic [15:0] dx_o, dy_o;
  logic        sat_o;
  side_t       s86;

  assign s86   = sd[ST_RND];
  assign frx   = sat_force(fm86x, s86.xpos);
  assign fry   = sat_force(fm86y, s86.ypos);
  // zero offset: no direction, no force
  assign fx_o  = s86.zero ? 32'd0 : frx[31:0];
  assign fy_o  = s86.zero ? 32'd0 : fry[31:0];
  assign dx_o  = s86.zero ? 16'd0 :
                 (s86.xneg ? (16'd0 - {1'b0, dir86x}) : {1'b0, dir86x});
  assign dy_o  = s86.zero ? 16'd0 :
                 (s86.yneg ? (16'd0 - {1'b0, dir86y}) : {1'b0, dir86y});
  assign sat_o = !s86.zero && (frx[32] || fry[32]);

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {6'd0, sat_o, s86.coll, dy_o, dx_o, fy_o, fx_o};
    end
  end

endmodule

FILE: design/pwsf_checker.sv
// Port-level checker for the pairwise softened force unit, with its bind.
`include "pairwise_softened_force_unit_assert.svh"

module pwsf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [pwsf_pkg::IN_W-1:0]      s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pwsf_pkg::OUT_W-1:0]     m_axis_tdata,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [pwsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [pwsf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pwsf_pkg::*;

  logic [31:0] fx, fy;
  logic [15:0] dx, dy;
  logic        sat, in_seen;

  assign fx  = m_axis_tdata[31:0];
  assign fy  = m_axis_tdata[63:32];
  assign dx  = m_axis_tdata[79:64];
  assign dy  = m_axis_tdata[95:80];
  assign sat = m_axis_tdata[97];
  assign in_seen = s_axis_tvalid && s_axis_tready && cfg_valid && cfg_ready
                   && (cfg_index == cfg_index) && (cfg_data == cfg_data)
                   && (s_axis_tdata == s_axis_tdata);

  // a result held back stays offered
  `PWSF_ASSERT_NXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // no direction means no force (only a zero offset gives both components zero)
  `PWSF_ASSERT_IMP(a_zero_dir, clk, rst, m_axis_tvalid && dx == 16'd0 && dy == 16'd0, fx == 32'd0 && fy == 32'd0 && !sat)
  // clipping only ever leaves a full-scale component
  `PWSF_ASSERT_IMP(a_sat_rail, clk, rst, m_axis_tvalid && sat, fx == 32'h8000_0000 || fx == 32'h7FFF_FFFF || fy == 32'h8000_0000 || fy == 32'h7FFF_FFFF)
  // each direction component stays within unit length, unless an input and a config write are taken together
  `PWSF_ASSERT_IMP(a_dir_range, clk, rst, m_axis_tvalid && !in_seen, $signed(dx) <= 16'sd16384 && $signed(dx) >= -16'sd16384 && $signed(dy) <= 16'sd16384 && $signed(dy) >= -16'sd16384)

endmodule

bind pairwise_softened_force_unit pwsf_checker u_pwsf_checker (.*);

FILE: test/tb.sv
// Self-checking testbench for the pairwise softened force unit.
`timescale 1ns / 1ps

module tb;
  import pwsf_pkg::*;

  typedef struct {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic        coll;
    logic        sat;
  } force_res_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // self_x, self_y, self_mass, other_x, other_y, other_mass (lowest first)
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // force_x, force_y, dir_x, dir_y, collides, saturated (lowest first)
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [31:0] soft_floor;
  logic [15:0] dist_div;
  logic [7:0]  gain;
  logic [31:0] half_width;

  logic [IN_W-1:0] pending_pairs[$];
  force_res_t      expected_forces[$];
  int unsigned     send_gap;
  int unsigned     recv_hold;
  int unsigned     results_seen;
  bit              long_hold_done;
  int unsigned     fails;

  pairwise_softened_force_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] t;
    res = 0;
    for (int i = 31; i >= 0; i--) begin
      t = res | (64'd1 << i);
      if (t * t <= n) res = t;
    end
    return res;
  endfunction

  // Rounded, signed-saturated force component; sign opposite to the offset
  function automatic logic [31:0] force_axis(input logic signed [32:0] d,
                                             input logic [63:0] dir_abs,
                                             input logic [63:0] mag,
                                             inout logic sat);
    logic [63:0] m;
    m = (dir_abs * mag + 64'd8192) >> 14;
    if (!d[32] && d != 0) begin
      if (m > 64'h8000_0000) begin
        m = 64'h8000_0000;
        sat = 1'b1;
      end
      return 32'd0 - m[31:0];
    end
    if (m > 64'h7FFF_FFFF) begin
      m = 64'h7FFF_FFFF;
      sat = 1'b1;
    end
    return m[31:0];
  endfunction

  function automatic force_res_t predict_force(input logic [IN_W-1:0] pkt);
    logic signed [32:0] dx, dy;
    logic [32:0]  a, b;
    logic [63:0]  na, nb, mx, len, dirx, diry, mag;
    logic [65:0]  dsq, sdist;
    logic [15:0]  dv;
    logic [127:0] num, q;
    logic         sat;
    force_res_t   r;
    dx = {pkt[31], pkt[31:0]} - {pkt[127], pkt[127:96]};
    dy = {pkt[63], pkt[63:32]} - {pkt[159], pkt[159:128]};
    a = dx[32] ? -dx : dx;
    b = dy[32] ? -dy : dy;
    r.coll = (a < {1'b0, half_width}) && (b < {1'b0, half_width});
    r.fx = 0; r.fy = 0; r.dir_x = 0; r.dir_y = 0; r.sat = 0;
    if (a == 0 && b == 0) return r;
    na = a; nb = b;
    mx = (na > nb) ? na : nb;
    while (mx < 64'h4000_0000) begin
      na = na << 1; nb = nb << 1; mx = mx << 1;
    end
    if (mx >= 64'h8000_0000) begin
      na = na >> 1; nb = nb >> 1;
    end
    len = root_floor(na * na + nb * nb);
    dirx = (na * 64'd16384 + (len >> 1)) / len;
    diry = (nb * 64'd16384 + (len >> 1)) / len;
    dsq = {33'd0, a} * {33'd0, a} + {33'd0, b} * {33'd0, b};
    dv = (dist_div == 0) ? 16'd1 : dist_div;
    sdist = (dsq >> 16) / dv;
    if (sdist > 66'hFFFF_FFFF) sdist = 66'hFFFF_FFFF;
    if (sdist < soft_floor) sdist = soft_floor;
    if (sdist == 0) sdist = 1;
    num = {96'd0, pkt[95:64]} * {96'd0, pkt[191:160]} * {120'd0, gain};
    q = num / sdist;
    mag = (q >= (128'd1 << 46)) ? (64'd1 << 46) : q[63:0];
    sat = 1'b0;
    r.fx = force_axis(dx, dirx, mag, sat);
    r.fy = force_axis(dy, diry, mag, sat);
    r.sat = sat;
    r.dir_x = dx[32] ? 16'd0 - dirx[15:0] : dirx[15:0];
    r.dir_y = dy[32] ? 16'd0 - diry[15:0] : diry[15:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 65) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_forces.push_back(predict_force(s_axis_tdata));
      if (s_axis_tvalid && !s_axis_tready) begin
        // stalled: hold the transaction
      end else if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (pending_pairs.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_pairs.pop_front();
        send_gap      <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    force_res_t e;
    if (rst) begin
      m_axis_tready  <= 1'b0;
      recv_hold      <= 0;
      results_seen   <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (expected_forces.size() == 0) begin
          $error("result with nothing expected: %h", m_axis_tdata);
          fails++;
        end else begin
          e = expected_forces.pop_front();
          if (m_axis_tdata[31:0] !== e.fx) begin
            $error("force_x expected %h actual %h", e.fx, m_axis_tdata[31:0]); fails++;
          end
          if (m_axis_tdata[63:32] !== e.fy) begin
            $error("force_y expected %h actual %h", e.fy, m_axis_tdata[63:32]); fails++;
          end
          if (m_axis_tdata[79:64] !== e.dir_x) begin
            $error("dir_x expected %h actual %h", e.dir_x, m_axis_tdata[79:64]); fails++;
          end
          if (m_axis_tdata[95:80] !== e.dir_y) begin
            $error("dir_y expected %h actual %h", e.dir_y, m_axis_tdata[95:80]); fails++;
          end
          if (m_axis_tdata[96] !== e.coll) begin
            $error("collides expected %b actual %b", e.coll, m_axis_tdata[96]); fails++;
          end
          if (m_axis_tdata[97] !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, m_axis_tdata[97]); fails++;
          end
        end
      end
      if (!long_hold_done && results_seen == 40) begin
        // long back-pressure so the pipeline fills and stalls its input
        long_hold_done <= 1'b1;
        recv_hold      <= 300;
        m_axis_tready  <= 1'b0;
      end else if (recv_hold != 0) begin
        recv_hold     <= recv_hold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < 75);
        if ($urandom_range(0, 99) < 2) recv_hold <= $urandom_range(10, 40);
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOFT_FLOOR: soft_floor = val;
      REG_DIST_DIV:   dist_div   = val[15:0];
      REG_FORCE_GAIN: gain       = val[7:0];
      default:        half_width = val;
    endcase
  endtask

  task automatic set_config(input logic [31:0] fl, input logic [15:0] dv,
                            input logic [7:0] g, input logic [31:0] hw);
    @(posedge clk);
    write_reg(REG_SOFT_FLOOR, fl);
    write_reg(REG_DIST_DIV, {16'd0, dv});
    write_reg(REG_FORCE_GAIN, {24'd0, g});
    write_reg(REG_HALF_WIDTH, hw);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || s_axis_tvalid || expected_forces.size() != 0);
  endtask

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rand_pair();
    logic [31:0] sx, sy, ox, oy;
    sx = $urandom; sy = $urandom; ox = $urandom; oy = $urandom;
    case ($urandom_range(0, 9))
      4, 5, 6: begin
        ox = sx + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        oy = sy + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      end
      7: begin
        ox = sx; oy = sy;
      end
      8: begin
        sx = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        ox = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      9: begin
        if ($urandom_range(0, 1)) ox = sx;
        else oy = sy;
      end
      default: ;
    endcase
    return {rand_mass(), oy, ox, rand_mass(), sy, sx};
  endfunction

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair());
  endtask

  initial begin
    logic [31:0] big;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = REG_SOFT_FLOOR;
    cfg_data      = '0;
    fails         = 0;
    soft_floor    = SOFT_FLOOR_RST;
    dist_div      = DIST_DIV_RST;
    gain          = FORCE_GAIN_RST;
    half_width    = HALF_WIDTH_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    big = 32'hFFFF_FFFF;

    // directed pairs under reset settings
    pending_pairs.push_back({32'h0001_0000, 32'd5, 32'd7, 32'h0001_0000, 32'd5, 32'd7});
    pending_pairs.push_back({big, 32'h8000_0000, 32'h8000_0000, big,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_pairs.push_back({big, 32'h7FFF_FFFF, 32'h7FFF_FFFF, big,
                             32'h8000_0000, 32'h8000_0000});
    pending_pairs.push_back({32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd1});
    pending_pairs.push_back({32'h0001_0000, 32'd1, 32'd0, 32'h0001_0000, 32'd0, 32'd0});
    pending_pairs.push_back({32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0});
    pending_pairs.push_back({big, 32'd0, 32'h0000_8000, big, 32'd0, 32'd0});
    pending_pairs.push_back({big, 32'h0001_0000, 32'h0001_0000, big, 32'd0, 32'd0});
    pending_pairs.push_back({32'h0002_0000, 32'h0003_0000, 32'hFFFE_0000, 32'h0005_0000,
                             32'h0000_0000, 32'h0001_0000});
    pending_pairs.push_back({32'h0001_0000, 32'd0, 32'h0001_1999, 32'h0001_0000,
                             32'd0, 32'd0});
    pending_pairs.push_back({32'h0001_0000, 32'd0, 32'h0001_199A, 32'h0001_0000,
                             32'd0, 32'd0});
    push_random(10);
    wait_idle();

    set_config(32'd1, 16'd1, 8'd255, big);
    push_random(150);
    wait_idle();

    set_config(big, 16'hFFFF, 8'd0, 32'd0);
    push_random(130);
    wait_idle();

    // zero floor and zero divisor
    set_config(32'd0, 16'd0, 8'd1, 32'h0001_0000);
    pending_pairs.push_back({32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd1});
    push_random(130);
    wait_idle();

    set_config(SOFT_FLOOR_RST, DIST_DIV_RST, FORCE_GAIN_RST, HALF_WIDTH_RST);
    push_random(150);
    wait_idle();

    for (int p = 0; p < 2; p++) begin
      set_config(32'($urandom_range(1, 32'h0010_0000)), 16'($urandom_range(1, 16'hFFFF)),
                 8'($urandom_range(0, 255)), 32'($urandom));
      push_random(150);
      wait_idle();
    end

    repeat (120) @(posedge clk);
    if (fails == 0) $display("pairwise_softened_force_unit regression: pass");
    else $display("pairwise_softened_force_unit regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("pairwise_softened_force_unit regression: fail");
    $finish;
  end

endmodule
